>>> hdl/pfa_pkg.sv
package pfa_pkg;

   // Table geometry
   localparam int NUM_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;

   // Fixed field widths of the request, response and register ports
   localparam int OP_BITS       = 1;
   localparam int SLOT_BITS     = 4;
   localparam int AMOUNT_BITS   = 16;
   localparam int MODE_BITS     = 2;
   localparam int PIU_BITS      = 5;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;

   // Derived widths
   localparam int IDX_BITS   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_PARTITIONS + 1);
   localparam int COUNT_BITS = (CNT_BITS > PIU_BITS) ? CNT_BITS : PIU_BITS;
   localparam int SLOTX_BITS = (COUNT_BITS > SLOT_BITS) ? COUNT_BITS : SLOT_BITS;
   localparam int CMP_BITS   = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;

   // Reset values of the registers
   localparam logic [MODE_BITS-1:0] FIT_MODE_RESET = 2'd0;
   localparam logic [PIU_BITS-1:0]  PIU_RESET      = 5'd16;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_ALLOC = 1'b1;

   // Placement policies; the unused code behaves as first fit
   localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;
   localparam logic [MODE_BITS-1:0] FIT_SPARE = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_MODE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PARTS    = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

>>> hdl/pfa_ram.sv
module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/partition_fit_allocator.sv
// Partition allocator with first, best and worst fit placement. A load writes one
// partition's free size and answers in the cycle after it is taken; busy stays low.
// A request reads the free-size RAM one entry per cycle, from index 0 up to
// min(partitions_in_use, NUM_PARTITIONS) - 1, then writes the chosen entry back:
// it keeps busy high for the whole scan, whose length is bounded by the single RAM
// read port, and answers in the cycle in which busy drops.
// Every item gives exactly one response, held on the rsp_ ports for one cycle with
// rsp_valid high; the receiver must take it then, as there is no back-pressure.
// The register port is always ready and is meant to be written while busy is low.
module partition_fit_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pfa_pkg::OP_BITS-1:0]         req_operation,
   input  logic [pfa_pkg::SLOT_BITS-1:0]       req_slot_index,
   input  logic [pfa_pkg::AMOUNT_BITS-1:0]     req_amount,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [pfa_pkg::SLOT_BITS-1:0]       rsp_chosen_slot,
   output logic [pfa_pkg::AMOUNT_BITS-1:0]     rsp_left_over,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pfa_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   import pfa_pkg::*;

   // Registers
   state_type                state_ff, state_in;
   logic [MODE_BITS-1:0]     fit_mode_ff;
   logic [PIU_BITS-1:0]      parts_ff;
   logic [NUM_PARTITIONS-1:0] vld_ff, vld_in;
   logic [COUNT_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic                     pend_ff, pend_in;
   logic [IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;
   logic                     pend_vld_ff, pend_vld_in;
   logic [AMOUNT_BITS-1:0]   amount_ff, amount_in;
   logic                     found_ff, found_in;
   logic [IDX_BITS-1:0]      pick_ff, pick_in;
   logic [SIZE_BITS-1:0]     best_ff, best_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_granted_ff, rsp_granted_in;
   logic [SLOT_BITS-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [AMOUNT_BITS-1:0]   rsp_left_ff, rsp_left_in;

   // Combinational signals
   logic                     accept;
   logic                     csr_write;
   logic [COUNT_BITS-1:0]    count_lim;
   logic                     scan_done;
   logic                     load_in_range;
   logic [IDX_BITS-1:0]      load_addr;
   logic [SIZE_BITS-1:0]     load_value;
   logic [SIZE_BITS-1:0]     rd_data;
   logic [SIZE_BITS-1:0]     cand_val;
   logic                     cand_fits;
   logic [SIZE_BITS-1:0]     cand_left;
   logic                     take_cand;
   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_BITS-1:0]      wr_addr;
   logic [SIZE_BITS-1:0]     wr_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Clamp the searched count to the table depth
   always_comb begin
      if (COUNT_BITS'(parts_ff) > COUNT_BITS'(NUM_PARTITIONS)) begin
         count_lim = COUNT_BITS'(NUM_PARTITIONS);
      end else begin
         count_lim = COUNT_BITS'(parts_ff);
      end
   end

   assign scan_done = (rd_idx_ff >= count_lim) && !pend_ff;

   // Load decode
   assign load_in_range = SLOTX_BITS'(req_slot_index) < SLOTX_BITS'(NUM_PARTITIONS);
   assign load_addr     = IDX_BITS'(req_slot_index);
   assign load_value    = SIZE_BITS'(req_amount);

   // Evaluate the entry returned by the RAM; unwritten entries read as zero
   assign cand_val  = pend_vld_ff ? rd_data : '0;
   assign cand_fits = CMP_BITS'(cand_val) >= CMP_BITS'(amount_ff);
   assign cand_left = SIZE_BITS'(CMP_BITS'(cand_val) - CMP_BITS'(amount_ff));

   always_comb begin
      take_cand = 1'b0;
      if (pend_ff && cand_fits) begin
         priority if (!found_ff) begin
            take_cand = 1'b1;
         end else if (fit_mode_ff == FIT_BEST) begin
            take_cand = cand_left < best_ff;
         end else if (fit_mode_ff == FIT_WORST) begin
            take_cand = cand_left > best_ff;
         end else begin
            take_cand = 1'b0;
         end
      end
   end

   // Sequencer: issue reads, track the pick, write back and respond
   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      pend_vld_in    = pend_vld_ff;
      amount_in      = amount_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      vld_in         = vld_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_left_in    = rsp_left_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = load_addr;
      wr_data        = load_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  wr_en          = load_in_range;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_slot_in    = req_slot_index;
                  rsp_left_in    = load_in_range ? AMOUNT_BITS'(load_value) : '0;
                  if (load_in_range) begin
                     vld_in[load_addr] = 1'b1;
                  end
               end else begin
                  state_in  = ST_SCAN;
                  rd_idx_in = '0;
                  amount_in = req_amount;
                  found_in  = 1'b0;
                  pick_in   = '0;
                  best_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            // Hold the running pick
            if (take_cand) begin
               found_in = 1'b1;
               pick_in  = pend_idx_ff;
               best_in  = cand_left;
            end
            // Issue the next read
            if (rd_idx_ff < count_lim) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IDX_BITS-1:0];
               pend_vld_in = vld_ff[rd_idx_ff[IDX_BITS-1:0]];
               rd_idx_in   = rd_idx_ff + COUNT_BITS'(1);
            end
            // Write back the chosen entry and respond
            if (scan_done) begin
               state_in       = ST_IDLE;
               wr_en          = found_ff;
               wr_addr        = pick_ff;
               wr_data        = best_ff;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_slot_in    = found_ff ? SLOT_BITS'(pick_ff) : '0;
               rsp_left_in    = found_ff ? AMOUNT_BITS'(best_ff) : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fit_mode_ff  <= FIT_MODE_RESET;
         parts_ff     <= PIU_RESET;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (csr_index == CSR_FIT_MODE) begin
               fit_mode_ff <= MODE_BITS'(csr_wdata);
            end else if (csr_index == CSR_PARTS) begin
               parts_ff <= PIU_BITS'(csr_wdata);
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      pend_idx_ff    <= pend_idx_in;
      pend_vld_ff    <= pend_vld_in;
      amount_ff      <= amount_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_left_ff    <= rsp_left_in;
   end

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_PARTITIONS)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_left_over   = rsp_left_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("read returned outside a scan");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_done) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("scan finished without a response");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && found_ff) |-> (COUNT_BITS'(pick_ff) < count_lim))
      else $error("pick outside searched partitions");

   a_grant_is_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff) |-> $past(state_ff == ST_SCAN))
      else $error("grant without a scan");
`endif

endmodule
